[sv/bsi_pkg.sv]
// Shared types and constants of the kd-tree box spatial index.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package bsi_pkg;

  localparam int unsigned TREE_DEPTH   = 4;
  localparam int unsigned MAX_ENTITIES = 1024;
  localparam int unsigned COORD_WIDTH  = 24;

  localparam int unsigned NODE_COUNT = (1 << (TREE_DEPTH + 1)) - 1;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned LVL_W      = $clog2(TREE_DEPTH + 1);
  localparam int unsigned ENT_AW     = $clog2(MAX_ENTITIES);
  localparam int unsigned LINK_W     = ENT_AW + 1;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned HIT_W      = $clog2(RESULT_CAP + 1);
  localparam int unsigned ONE_UNIT   = 8;
  localparam int unsigned ID_W       = 10;
  localparam int unsigned MAXH_W     = 7;
  localparam int unsigned PADDR_W    = 5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_LINK   = 2'd1,
    FUNC_UNLINK = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_MIN_X    = 3'd0,
    REG_MAX_X    = 3'd1,
    REG_MIN_Y    = 3'd2,
    REG_MAX_Y    = 3'd3,
    REG_MAX_HITS = 3'd4
  } reg_e;

  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   entity_id;
    coord_t            origin_x;
    coord_t            origin_y;
    coord_t            origin_z;
    coord_t            box_lo_x;
    coord_t            box_lo_y;
    coord_t            box_lo_z;
    coord_t            box_hi_x;
    coord_t            box_hi_y;
    coord_t            box_hi_z;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] hit_entity;
    logic            hit_valid;
    logic [4:0]      node_index;
    logic            was_linked;
    logic            truncated;
    logic            last;
  } result_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    func_e             func;
    logic              id_ok;
    logic [ENT_AW-1:0] id;
    box_t              box;
  } cmd_t;

  typedef struct packed {
    coord_t              min_x;
    coord_t              max_x;
    coord_t              min_y;
    coord_t              max_y;
    logic [MAXH_W-1:0]   max_hits;
  } cfg_t;

endpackage
`default_nettype wire

[sv/bsi_front.sv]
// Front end: accepts items, forms absolute link boxes, checks entity ids.
// Depends on bsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsi_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire bsi_pkg::item_t item_i,
  input  wire logic          q_full_i,
  output bsi_pkg::cmd_t      cmd_o,
  output logic               push_o,
  output logic               hold_o
);
  import bsi_pkg::*;

  localparam int unsigned SW = COORD_WIDTH + 2;
  localparam logic signed [SW-1:0] UNIT = SW'(ONE_UNIT);

  logic  fr_v_q, fr_v_d;
  cmd_t  fr_q, fr_d;

  function automatic coord_t sat_sum(coord_t a, coord_t b, logic signed [SW-1:0] adj);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b) + adj;
    if (s[SW-1:COORD_WIDTH-1] == {(SW-COORD_WIDTH+1){s[SW-1]}}) begin
      return s[COORD_WIDTH-1:0];
    end else if (s[SW-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  always_comb begin
    fr_d       = fr_q;
    fr_d.func  = item_i.func;
    fr_d.id_ok = ({{(32-ID_W){1'b0}}, item_i.entity_id} < 32'(MAX_ENTITIES));
    fr_d.id    = ENT_AW'(item_i.entity_id);
    if (item_i.func == FUNC_LINK) begin
      // widen by one unit around the origin-relative box
      fr_d.box.lo_x = sat_sum(item_i.origin_x, item_i.box_lo_x, -UNIT);
      fr_d.box.lo_y = sat_sum(item_i.origin_y, item_i.box_lo_y, -UNIT);
      fr_d.box.lo_z = sat_sum(item_i.origin_z, item_i.box_lo_z, -UNIT);
      fr_d.box.hi_x = sat_sum(item_i.origin_x, item_i.box_hi_x, UNIT);
      fr_d.box.hi_y = sat_sum(item_i.origin_y, item_i.box_hi_y, UNIT);
      fr_d.box.hi_z = sat_sum(item_i.origin_z, item_i.box_hi_z, UNIT);
    end else begin
      fr_d.box.lo_x = item_i.box_lo_x;
      fr_d.box.lo_y = item_i.box_lo_y;
      fr_d.box.lo_z = item_i.box_lo_z;
      fr_d.box.hi_x = item_i.box_hi_x;
      fr_d.box.hi_y = item_i.box_hi_y;
      fr_d.box.hi_z = item_i.box_hi_z;
    end
  end

  assign push_o = fr_v_q && !q_full_i;
  assign hold_o = fr_v_q && q_full_i;
  assign cmd_o  = fr_q;
  assign fr_v_d = accept_i || (fr_v_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else begin
      fr_v_q <= fr_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fr_q <= fr_d;
    end
  end

endmodule
`default_nettype wire

[sv/bsi_queue.sv]
// Two-entry command queue between front and back.
// Depends on bsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsi_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bsi_pkg::cmd_t push_data_i,
  input  wire logic          pop_i,
  output bsi_pkg::cmd_t      head_o,
  output logic               empty_o,
  output logic               full_o
);
  import bsi_pkg::*;

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[sv/bsi_back.sv]
// Back end: tree build, chain link/unlink and depth-first query walk.
// Holds the entity memories and split tables. Depends on bsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsi_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bsi_pkg::cfg_t  cfg_i,
  input  wire bsi_pkg::cmd_t  cmd_i,
  input  wire logic           q_empty_i,
  output logic                pop_o,
  output logic                res_valid_o,
  output bsi_pkg::result_t    res_o
);
  import bsi_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_SWEEP  = 16'h0002,
    ST_BVISIT = 16'h0004,
    ST_BBACK  = 16'h0008,
    ST_URD    = 16'h0010,
    ST_UCHK   = 16'h0020,
    ST_UWRD   = 16'h0040,
    ST_UWCHK  = 16'h0080,
    ST_LDESC  = 16'h0100,
    ST_LWR    = 16'h0200,
    ST_QVISIT = 16'h0400,
    ST_QRD    = 16'h0800,
    ST_QCHK   = 16'h1000,
    ST_QKIDS  = 16'h2000,
    ST_QBACK  = 16'h4000,
    ST_QEND   = 16'h8000
  } state_e;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } bounds_t;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_ENTITIES);
  localparam logic [LVL_W-1:0]  LEAF = LVL_W'(TREE_DEPTH);

  function automatic logic [NODE_W-1:0] child1_off(logic [LVL_W-1:0] lvl);
    return NODE_W'(1) << (LEAF - lvl);
  endfunction

  // entity memories
  logic [LINK_W-1:0] next_mem [MAX_ENTITIES];
  logic [NODE_W-1:0] node_mem [MAX_ENTITIES];
  box_t              box_mem  [MAX_ENTITIES];
  logic              lnk_mem  [MAX_ENTITIES];

  logic [ENT_AW-1:0] rd_addr;
  logic [LINK_W-1:0] next_rd;
  logic [NODE_W-1:0] node_rd;
  box_t              box_rd;
  logic              lnk_rd;

  logic              nx_we, nd_we, bx_we, lk_we, lk_wd;
  logic [ENT_AW-1:0] nx_wa, lk_wa;
  logic [LINK_W-1:0] nx_wd;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [NODE_W-1:0] nstk_q [TREE_DEPTH+1];
  logic [NODE_W-1:0] nstk_d [TREE_DEPTH+1];
  logic              pend_q [TREE_DEPTH+1];
  logic              pend_d [TREE_DEPTH+1];
  bounds_t           bnd_q  [TREE_DEPTH+1];
  bounds_t           bnd_d  [TREE_DEPTH+1];
  logic              ax_q   [NODE_COUNT];
  logic              ax_d   [NODE_COUNT];
  coord_t            sd_q   [NODE_COUNT];
  coord_t            sd_d   [NODE_COUNT];
  logic [LINK_W-1:0] head_q [NODE_COUNT];
  logic [LINK_W-1:0] head_d [NODE_COUNT];
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] nid_q, nid_d;
  logic [NODE_W-1:0] ln_q, ln_d;
  logic              was_q, was_d;
  logic [HIT_W-1:0]  hcnt_q, hcnt_d;
  logic              trunc_q, trunc_d;
  logic              pv_q, pv_d;
  logic [LINK_W-1:0] pid_q, pid_d;
  logic [ENT_AW:0]   sw_q, sw_d;
  logic              quiet_q, quiet_d;
  result_t           res_q, res_d;
  logic              res_v_q, res_v_d;

  // scratch for the combinational step
  logic [NODE_W-1:0]       cn, pn;
  logic [LVL_W-1:0]        pl;
  bounds_t                 cb, pb;
  logic signed [COORD_WIDTH:0] bdx, bdy, bsum;
  coord_t                  split, amin, amax;
  logic                    bax, hit, go0, go1;
  logic [HIT_W-1:0]        limit;

  assign rd_addr = (state_q == ST_URD) ? cmd_q.id : cur_q[ENT_AW-1:0];

  always_ff @(posedge clk_i) begin
    next_rd <= next_mem[rd_addr];
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    node_rd <= node_mem[rd_addr];
    if (nd_we) begin
      node_mem[cmd_q.id] <= ln_q;
    end
  end

  always_ff @(posedge clk_i) begin
    box_rd <= box_mem[rd_addr];
    if (bx_we) begin
      box_mem[cmd_q.id] <= cmd_q.box;
    end
  end

  always_ff @(posedge clk_i) begin
    lnk_rd <= lnk_mem[rd_addr];
    if (lk_we) begin
      lnk_mem[lk_wa] <= lk_wd;
    end
  end

  always_comb begin
    if (cfg_i.max_hits == '0) begin
      limit = HIT_W'(1);
    end else if (HIT_W'(cfg_i.max_hits) > HIT_W'(RESULT_CAP)) begin
      limit = HIT_W'(RESULT_CAP);
    end else begin
      limit = HIT_W'(cfg_i.max_hits);
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    lvl_d   = lvl_q;
    nstk_d  = nstk_q;
    pend_d  = pend_q;
    bnd_d   = bnd_q;
    ax_d    = ax_q;
    sd_d    = sd_q;
    head_d  = head_q;
    cur_d   = cur_q;
    nid_d   = nid_q;
    ln_d    = ln_q;
    was_d   = was_q;
    hcnt_d  = hcnt_q;
    trunc_d = trunc_q;
    pv_d    = pv_q;
    pid_d   = pid_q;
    sw_d    = sw_q;
    quiet_d = quiet_q;
    res_d   = '0;
    res_v_d = 1'b0;
    pop_o   = 1'b0;
    nx_we = 1'b0; nx_wa = cmd_q.id; nx_wd = nid_q;
    nd_we = 1'b0; bx_we = 1'b0;
    lk_we = 1'b0; lk_wa = cmd_q.id; lk_wd = 1'b0;

    cn   = nstk_q[lvl_q];
    cb   = bnd_q[lvl_q];
    pl   = lvl_q - LVL_W'(1);
    pn   = nstk_q[pl];
    pb   = bnd_q[pl];
    bdx  = (COORD_WIDTH+1)'(cb.max_x) - (COORD_WIDTH+1)'(cb.min_x);
    bdy  = (COORD_WIDTH+1)'(cb.max_y) - (COORD_WIDTH+1)'(cb.min_y);
    bax  = !(bdx > bdy);
    bsum = bax ? ((COORD_WIDTH+1)'(cb.min_y) + (COORD_WIDTH+1)'(cb.max_y))
               : ((COORD_WIDTH+1)'(cb.min_x) + (COORD_WIDTH+1)'(cb.max_x));
    split = sd_q[(state_q == ST_LDESC) ? ln_q : cn];
    amin  = ax_q[ln_q] ? cmd_q.box.lo_y : cmd_q.box.lo_x;
    amax  = ax_q[ln_q] ? cmd_q.box.hi_y : cmd_q.box.hi_x;
    go0   = (ax_q[cn] ? cmd_q.box.hi_y : cmd_q.box.hi_x) > split;
    go1   = (ax_q[cn] ? cmd_q.box.lo_y : cmd_q.box.lo_x) < split;
    hit   = !(box_rd.lo_x > cmd_q.box.hi_x || box_rd.lo_y > cmd_q.box.hi_y ||
              box_rd.lo_z > cmd_q.box.hi_z || box_rd.hi_x < cmd_q.box.lo_x ||
              box_rd.hi_y < cmd_q.box.lo_y || box_rd.hi_z < cmd_q.box.lo_z);

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          was_d = 1'b0;
          unique case (cmd_i.func)
            FUNC_CLEAR: begin
              for (int i = 0; i < NODE_COUNT; i++) begin
                head_d[i] = NIL;
              end
              sw_d    = '0;
              quiet_d = 1'b0;
              state_d = ST_SWEEP;
            end
            FUNC_LINK, FUNC_UNLINK: begin
              if (cmd_i.id_ok) begin
                state_d = ST_URD;
              end else begin
                res_d.last = 1'b1;
                res_v_d    = 1'b1;
              end
            end
            FUNC_QUERY: begin
              hcnt_d    = '0;
              trunc_d   = 1'b0;
              pv_d      = 1'b0;
              lvl_d     = '0;
              nstk_d[0] = '0;
              state_d   = ST_QVISIT;
            end
            default: ;
          endcase
        end
      end

      // mark every entity unlinked, one entry a cycle
      ST_SWEEP: begin
        lk_we = 1'b1;
        lk_wa = sw_q[ENT_AW-1:0];
        sw_d  = sw_q + 1'b1;
        if (sw_q == (ENT_AW+1)'(MAX_ENTITIES - 1)) begin
          lvl_d          = '0;
          nstk_d[0]      = '0;
          bnd_d[0].min_x = cfg_i.min_x;
          bnd_d[0].max_x = cfg_i.max_x;
          bnd_d[0].min_y = cfg_i.min_y;
          bnd_d[0].max_y = cfg_i.max_y;
          state_d        = ST_BVISIT;
        end
      end

      ST_BVISIT: begin
        if (lvl_q == LEAF) begin
          ax_d[cn] = 1'b0;
          sd_d[cn] = '0;
          state_d  = ST_BBACK;
        end else begin
          ax_d[cn]   = bax;
          sd_d[cn]   = bsum[COORD_WIDTH:1];
          pend_d[lvl_q] = 1'b1;
          bnd_d[lvl_q + LVL_W'(1)] = cb;
          if (bax) begin
            bnd_d[lvl_q + LVL_W'(1)].min_y = bsum[COORD_WIDTH:1];
          end else begin
            bnd_d[lvl_q + LVL_W'(1)].min_x = bsum[COORD_WIDTH:1];
          end
          nstk_d[lvl_q + LVL_W'(1)] = cn + NODE_W'(1);
          lvl_d = lvl_q + LVL_W'(1);
        end
      end

      ST_BBACK: begin
        if (lvl_q == '0) begin
          res_d.last = 1'b1;
          res_v_d    = !quiet_q;
          state_d    = ST_IDLE;
        end else if (pend_q[pl]) begin
          pend_d[pl] = 1'b0;
          bnd_d[lvl_q] = pb;
          if (ax_q[pn]) begin
            bnd_d[lvl_q].max_y = sd_q[pn];
          end else begin
            bnd_d[lvl_q].max_x = sd_q[pn];
          end
          nstk_d[lvl_q] = pn + child1_off(pl);
          state_d = ST_BVISIT;
        end else begin
          lvl_d = pl;
        end
      end

      ST_URD: begin
        state_d = ST_UCHK;
      end

      ST_UCHK: begin
        if (lnk_rd) begin
          was_d = 1'b1;
          lk_we = 1'b1;
          if (head_q[node_rd] == {1'b0, cmd_q.id}) begin
            head_d[node_rd] = next_rd;
          end else begin
            cur_d   = head_q[node_rd];
            nid_d   = next_rd;
            state_d = ST_UWRD;
          end
        end
        if (!lnk_rd || head_q[node_rd] == {1'b0, cmd_q.id}) begin
          if (cmd_q.func == FUNC_LINK) begin
            ln_d    = '0;
            lvl_d   = '0;
            state_d = ST_LDESC;
          end else begin
            res_d.was_linked = lnk_rd;
            res_d.last       = 1'b1;
            res_v_d          = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end

      ST_UWRD: begin
        state_d = ST_UWCHK;
      end

      // find the predecessor and splice the entity out
      ST_UWCHK: begin
        if (next_rd == {1'b0, cmd_q.id} || next_rd[LINK_W-1]) begin
          if (next_rd == {1'b0, cmd_q.id}) begin
            nx_we = 1'b1;
            nx_wa = cur_q[ENT_AW-1:0];
            nx_wd = nid_q;
          end
          if (cmd_q.func == FUNC_LINK) begin
            ln_d    = '0;
            lvl_d   = '0;
            state_d = ST_LDESC;
          end else begin
            res_d.was_linked = 1'b1;
            res_d.last       = 1'b1;
            res_v_d          = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          cur_d   = next_rd;
          state_d = ST_UWRD;
        end
      end

      ST_LDESC: begin
        if (lvl_q == LEAF) begin
          state_d = ST_LWR;
        end else if (amin > split) begin
          ln_d  = ln_q + NODE_W'(1);
          lvl_d = lvl_q + LVL_W'(1);
        end else if (amax < split) begin
          ln_d  = ln_q + child1_off(lvl_q);
          lvl_d = lvl_q + LVL_W'(1);
        end else begin
          state_d = ST_LWR;
        end
      end

      ST_LWR: begin
        nx_we = 1'b1;
        nx_wa = cmd_q.id;
        nx_wd = head_q[ln_q];
        nd_we = 1'b1;
        bx_we = 1'b1;
        lk_we = 1'b1;
        lk_wd = 1'b1;
        head_d[ln_q] = {1'b0, cmd_q.id};
        res_d.node_index = 5'(ln_q);
        res_d.was_linked = was_q;
        res_d.last       = 1'b1;
        res_v_d          = 1'b1;
        state_d          = ST_IDLE;
      end

      ST_QVISIT: begin
        cur_d   = head_q[cn];
        state_d = head_q[cn][LINK_W-1] ? ST_QKIDS : ST_QRD;
      end

      ST_QRD: begin
        state_d = ST_QCHK;
      end

      // hold one hit back so the final one can carry last and truncated
      ST_QCHK: begin
        if (hit && hcnt_q >= limit) begin
          trunc_d = 1'b1;
          state_d = ST_QEND;
        end else begin
          if (hit) begin
            hcnt_d = hcnt_q + HIT_W'(1);
            pv_d   = 1'b1;
            pid_d  = cur_q;
            if (pv_q) begin
              res_d.hit_entity = ID_W'(pid_q);
              res_d.hit_valid  = 1'b1;
              res_v_d          = 1'b1;
            end
          end
          cur_d   = next_rd;
          state_d = next_rd[LINK_W-1] ? ST_QKIDS : ST_QRD;
        end
      end

      ST_QKIDS: begin
        if (lvl_q == LEAF || (!go0 && !go1)) begin
          state_d = ST_QBACK;
        end else if (go0) begin
          pend_d[lvl_q] = go1;
          nstk_d[lvl_q + LVL_W'(1)] = cn + NODE_W'(1);
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_QVISIT;
        end else begin
          pend_d[lvl_q] = 1'b0;
          nstk_d[lvl_q + LVL_W'(1)] = cn + child1_off(lvl_q);
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_QVISIT;
        end
      end

      ST_QBACK: begin
        if (lvl_q == '0) begin
          state_d = ST_QEND;
        end else if (pend_q[pl]) begin
          pend_d[pl]    = 1'b0;
          nstk_d[lvl_q] = pn + child1_off(pl);
          state_d       = ST_QVISIT;
        end else begin
          lvl_d = pl;
        end
      end

      ST_QEND: begin
        res_d.hit_entity = pv_q ? ID_W'(pid_q) : '0;
        res_d.hit_valid  = pv_q;
        res_d.truncated  = trunc_q;
        res_d.last       = 1'b1;
        res_v_d          = 1'b1;
        state_d          = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      sw_q    <= '0;
      quiet_q <= 1'b1;
      res_v_q <= 1'b0;
      lvl_q   <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        head_q[i] <= NIL;
      end
      for (int i = 0; i <= TREE_DEPTH; i++) begin
        pend_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
      quiet_q <= quiet_d;
      res_v_q <= res_v_d;
      lvl_q   <= lvl_d;
      head_q  <= head_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    nstk_q  <= nstk_d;
    bnd_q   <= bnd_d;
    ax_q    <= ax_d;
    sd_q    <= sd_d;
    cur_q   <= cur_d;
    nid_q   <= nid_d;
    ln_q    <= ln_d;
    was_q   <= was_d;
    hcnt_q  <= hcnt_d;
    trunc_q <= trunc_d;
    pv_q    <= pv_d;
    pid_q   <= pid_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

[sv/box_spatial_index_kd_tree.sv]
// Top level of the kd-tree box spatial index: APB registers, front, queue, back.
// Depends on bsi_pkg, bsi_front, bsi_queue, bsi_back.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   direction  handshake                        payload
//  command   in         start high, busy low             item_i (item_t)
//  result    out        result_valid_o, one cycle        result_o (result_t)
//  config    in/out     psel/penable/pwrite, pready = 1  paddr, pwdata, prdata
//
// Link and unlink walk the node chain to find the predecessor; link then
// descends the tree level by level. A query visits nodes and scans their chain
// entries. A clear sweeps the linked flags of all MAX_ENTITIES entries and
// rebuilds the split tables of all NODE_COUNT nodes. Reset runs the same sweep
// and rebuild before the first item is served; items are still queued during it.
// The receiver cannot stall: each result shows for one cycle. Up to three
// commands may be accepted ahead of the back end, then busy rises.
//
module box_spatial_index_kd_tree (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bsi_pkg::item_t                item_i,
  output logic                               result_valid_o,
  output bsi_pkg::result_t                   result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsi_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import bsi_pkg::*;

  cfg_t  cfg_q;
  cmd_t  fr_cmd, q_head;
  logic  accept, push, pop, hold, q_empty, q_full, wr_en;
  reg_e  sel;

  // take a transaction only when the front end has room
  assign accept = start && !busy;
  assign busy   = hold;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x    <= coord_t'(-524288);
      cfg_q.max_x    <= coord_t'(524288);
      cfg_q.min_y    <= coord_t'(-524288);
      cfg_q.max_y    <= coord_t'(524288);
      cfg_q.max_hits <= MAXH_W'(RESULT_CAP);
    end else if (wr_en) begin
      unique case (sel)
        REG_MIN_X:    cfg_q.min_x    <= pwdata[COORD_WIDTH-1:0];
        REG_MAX_X:    cfg_q.max_x    <= pwdata[COORD_WIDTH-1:0];
        REG_MIN_Y:    cfg_q.min_y    <= pwdata[COORD_WIDTH-1:0];
        REG_MAX_Y:    cfg_q.max_y    <= pwdata[COORD_WIDTH-1:0];
        REG_MAX_HITS: cfg_q.max_hits <= pwdata[MAXH_W-1:0];
        default: ;
      endcase
    end
  end

  // return the stored value, sign-extended for the bounds
  always_comb begin
    unique case (sel)
      REG_MIN_X:    prdata = 32'(cfg_q.min_x);
      REG_MAX_X:    prdata = 32'(cfg_q.max_x);
      REG_MIN_Y:    prdata = 32'(cfg_q.min_y);
      REG_MAX_Y:    prdata = 32'(cfg_q.max_y);
      REG_MAX_HITS: prdata = 32'(cfg_q.max_hits);
      default:      prdata = '0;
    endcase
  end

  bsi_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .q_full_i (q_full),
    .cmd_o    (fr_cmd),
    .push_o   (push),
    .hold_o   (hold)
  );

  bsi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (fr_cmd),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  bsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (q_head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule
`default_nettype wire

[sv/bsi_checker.sv]
// Port-level checks of the spatial index results, bound to the top level.
// Depends on bsi_pkg and box_spatial_index_kd_tree.
`timescale 1ns / 1ps
`default_nettype none
module bsi_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        result_valid_o,
  input wire bsi_pkg::result_t            result_o,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pready
);

  a_miss_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.hit_valid |-> result_o.last && result_o.hit_entity == '0)
    else $error("non-hit result not final or carries an id");

  a_trunc_on_last_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.truncated |-> result_o.hit_valid && result_o.last)
    else $error("truncation flagged outside the final hit");

  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.hit_valid |-> result_o.node_index == '0 && !result_o.was_linked)
    else $error("query hit carries link fields");

  a_apb_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("apb access not completed");

endmodule

bind box_spatial_index_kd_tree bsi_checker u_bsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .psel           (psel),
  .penable        (penable),
  .pready         (pready)
);
`default_nettype wire

[tb/box_spatial_index_kd_tree_tb.sv]
// Self-checking testbench of the kd-tree box spatial index: directed, config and random tests.
// Depends on bsi_pkg and box_spatial_index_kd_tree; an internal predictor models the tree.
`timescale 1ns / 1ps
`default_nettype none
module box_spatial_index_kd_tree_tb;
  import bsi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned NIL         = MAX_ENTITIES;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned TAIL_WAIT   = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  wire logic           busy;
  item_t               item_i = '0;
  wire logic           result_valid_o;
  result_t             result_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  wire logic [31:0]    prdata;
  wire logic           pready;

  always #6 clk_i = ~clk_i;

  box_spatial_index_kd_tree dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register shadow, split tables and the entity chains.
  // ---------------------------------------------------------------------------
  longint      shadow_min_x, shadow_max_x, shadow_min_y, shadow_max_y;
  int unsigned shadow_max_hits;

  bit          split_on_y [NODE_COUNT];
  longint      split_at   [NODE_COUNT];
  int unsigned chain_first[NODE_COUNT];
  int unsigned chain_link [MAX_ENTITIES];
  int unsigned home_node  [MAX_ENTITIES];
  bit          is_linked  [MAX_ENTITIES];
  longint      stored_lo  [MAX_ENTITIES][3];
  longint      stored_hi  [MAX_ENTITIES][3];

  result_t     pending_results[$];

  int unsigned items_sent, results_seen, mismatches, trunc_seen, hits_seen;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;

  function automatic int unsigned subtree_nodes(int unsigned level);
    return (1 << (TREE_DEPTH - level + 1)) - 1;
  endfunction

  function automatic longint clamp_coord(longint v);
    longint top, bottom;
    top    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    bottom = -(longint'(1) <<< (COORD_WIDTH - 1));
    if (v > top) return top;
    if (v < bottom) return bottom;
    return v;
  endfunction

  // Rebuild the split tables in pre-order; a parent always precedes its children.
  function automatic void rebuild_splits();
    longint      mnx[NODE_COUNT], mxx[NODE_COUNT], mny[NODE_COUNT], mxy[NODE_COUNT];
    int unsigned lvl[NODE_COUNT];
    int unsigned c1;
    longint      d;
    mnx[0] = shadow_min_x; mxx[0] = shadow_max_x;
    mny[0] = shadow_min_y; mxy[0] = shadow_max_y;
    lvl[0] = 0;
    for (int unsigned n = 0; n < NODE_COUNT; n++) begin
      if (lvl[n] >= TREE_DEPTH) begin
        split_on_y[n] = 1'b0;
        split_at[n]   = 0;
        continue;
      end
      c1 = n + 1 + subtree_nodes(lvl[n] + 1);
      lvl[n+1] = lvl[n] + 1;
      lvl[c1]  = lvl[n] + 1;
      mnx[n+1] = mnx[n]; mxx[n+1] = mxx[n]; mny[n+1] = mny[n]; mxy[n+1] = mxy[n];
      mnx[c1]  = mnx[n]; mxx[c1]  = mxx[n]; mny[c1]  = mny[n]; mxy[c1]  = mxy[n];
      if ((mxx[n] - mnx[n]) > (mxy[n] - mny[n])) begin
        d = (mnx[n] + mxx[n]) >>> 1;
        split_on_y[n] = 1'b0;
        mnx[n+1] = d;
        mxx[c1]  = d;
      end else begin
        d = (mny[n] + mxy[n]) >>> 1;
        split_on_y[n] = 1'b1;
        mny[n+1] = d;
        mxy[c1]  = d;
      end
      split_at[n] = d;
    end
  endfunction

  function automatic void clear_index();
    for (int unsigned n = 0; n < NODE_COUNT; n++) chain_first[n] = NIL;
    for (int unsigned e = 0; e < MAX_ENTITIES; e++) is_linked[e] = 1'b0;
    rebuild_splits();
  endfunction

  // Drop an entity from its node chain; report whether it was there.
  function automatic bit detach_entity(int unsigned id);
    int unsigned node, cur;
    if (!is_linked[id]) return 1'b0;
    is_linked[id] = 1'b0;
    node = home_node[id];
    if (chain_first[node] == id) begin
      chain_first[node] = chain_link[id];
      return 1'b1;
    end
    cur = chain_first[node];
    for (int unsigned s = 0; s < MAX_ENTITIES && cur < NIL; s++) begin
      if (chain_link[cur] == id) begin
        chain_link[cur] = chain_link[id];
        return 1'b1;
      end
      cur = chain_link[cur];
    end
    return 1'b1;
  endfunction

  // Work out the results of one accepted transaction and queue them.
  function automatic void predict_transaction(item_t it);
    result_t     r;
    longint      org[3], lo[3], hi[3], amin[3], amax[3];
    int unsigned node, level, limit, cur, c1;
    int unsigned stack_node[64], stack_lvl[64];
    int          sp;
    int unsigned hits[$];
    bit          trunc, miss;
    org[0] = it.origin_x; org[1] = it.origin_y; org[2] = it.origin_z;
    lo[0]  = it.box_lo_x; lo[1]  = it.box_lo_y; lo[2]  = it.box_lo_z;
    hi[0]  = it.box_hi_x; hi[1]  = it.box_hi_y; hi[2]  = it.box_hi_z;
    r = '0;
    r.last = 1'b1;
    case (it.func)
      FUNC_CLEAR: begin
        clear_index();
        pending_results.push_back(r);
      end
      FUNC_LINK: begin
        r.was_linked = detach_entity(it.entity_id);
        for (int a = 0; a < 3; a++) begin
          amin[a] = clamp_coord(org[a] + lo[a] - ONE_UNIT);
          amax[a] = clamp_coord(org[a] + hi[a] + ONE_UNIT);
        end
        node = 0;
        level = 0;
        while (level < TREE_DEPTH) begin
          if (amin[split_on_y[node]] > split_at[node]) node = node + 1;
          else if (amax[split_on_y[node]] < split_at[node])
            node = node + 1 + subtree_nodes(level + 1);
          else break;
          level++;
        end
        for (int a = 0; a < 3; a++) begin
          stored_lo[it.entity_id][a] = amin[a];
          stored_hi[it.entity_id][a] = amax[a];
        end
        home_node[it.entity_id]  = node;
        chain_link[it.entity_id] = chain_first[node];
        chain_first[node]        = it.entity_id;
        is_linked[it.entity_id]  = 1'b1;
        r.node_index = node[4:0];
        pending_results.push_back(r);
      end
      FUNC_UNLINK: begin
        r.was_linked = detach_entity(it.entity_id);
        pending_results.push_back(r);
      end
      default: begin
        limit = shadow_max_hits;
        if (limit < 1) limit = 1;
        if (limit > RESULT_CAP) limit = RESULT_CAP;
        trunc = 1'b0;
        // Depth-first walk: scan the chain, then child 0 before child 1.
        // Once the hit list is full any further overlap only flags truncation.
        sp = 1;
        stack_node[0] = 0;
        stack_lvl[0]  = 0;
        while (sp > 0) begin
          sp--;
          node  = stack_node[sp];
          level = stack_lvl[sp];
          cur = chain_first[node];
          for (int unsigned s = 0; s < MAX_ENTITIES && cur < NIL; s++) begin
            miss = 1'b0;
            for (int a = 0; a < 3; a++)
              if (stored_lo[cur][a] > hi[a] || stored_hi[cur][a] < lo[a]) miss = 1'b1;
            if (!miss) begin
              if (hits.size() >= limit) trunc = 1'b1;
              else hits.push_back(cur);
            end
            cur = chain_link[cur];
          end
          if (level >= TREE_DEPTH) continue;
          c1 = node + 1 + subtree_nodes(level + 1);
          if (lo[split_on_y[node]] < split_at[node]) begin
            stack_node[sp] = c1; stack_lvl[sp] = level + 1; sp++;
          end
          if (hi[split_on_y[node]] > split_at[node]) begin
            stack_node[sp] = node + 1; stack_lvl[sp] = level + 1; sp++;
          end
        end
        if (hits.size() == 0) begin
          r.truncated = trunc;
          pending_results.push_back(r);
        end else begin
          foreach (hits[i]) begin
            r = '0;
            r.hit_entity = hits[i][ID_W-1:0];
            r.hit_valid  = 1'b1;
            if (i == hits.size() - 1) begin
              r.truncated = trunc;
              r.last      = 1'b1;
            end
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every strobed result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (result_o.hit_valid) hits_seen++;
      if (result_o.truncated) trunc_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: entity %0d valid %0b node %0d linked %0b trunc %0b last %0b",
                   $time, result_o.hit_entity, result_o.hit_valid, result_o.node_index,
                   result_o.was_linked, result_o.truncated, result_o.last);
      end else begin
        want = pending_results.pop_front();
        if (result_o.hit_entity !== want.hit_entity || result_o.hit_valid !== want.hit_valid ||
            result_o.node_index !== want.node_index || result_o.was_linked !== want.was_linked ||
            result_o.truncated !== want.truncated || result_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result mismatch: exp ent %0d v %0b node %0d wl %0b tr %0b last %0b, got ent %0d v %0b node %0d wl %0b tr %0b last %0b",
                     $time, want.hit_entity, want.hit_valid, want.node_index, want.was_linked,
                     want.truncated, want.last, result_o.hit_entity, result_o.hit_valid,
                     result_o.node_index, result_o.was_linked, result_o.truncated, result_o.last);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one transaction, idling first at the current sender rate, and hold it
  // until accepted. start stays high so back-to-back transactions need no gap.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_transaction(it);
    items_sent++;
  endtask

  // Hold the sender until every expected result has arrived, then settle.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_X:    shadow_min_x = longint'($signed(value[COORD_WIDTH-1:0]));
      REG_MAX_X:    shadow_max_x = longint'($signed(value[COORD_WIDTH-1:0]));
      REG_MIN_Y:    shadow_min_y = longint'($signed(value[COORD_WIDTH-1:0]));
      REG_MAX_Y:    shadow_max_y = longint'($signed(value[COORD_WIDTH-1:0]));
      default:      shadow_max_hits = value[MAXH_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  // Write the full register set while idle; the tree picks it up at the next clear.
  task automatic program_index(int mnx, int mxx, int mny, int mxy, int hits);
    drain_results();
    write_reg(REG_MIN_X, 32'(mnx));
    write_reg(REG_MAX_X, 32'(mxx));
    write_reg(REG_MIN_Y, 32'(mny));
    write_reg(REG_MAX_Y, 32'(mxy));
    write_reg(REG_MAX_HITS, 32'(hits));
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic item_t plain_item(func_e f, int id);
    item_t it;
    it = '0;
    it.func = f;
    it.entity_id = ID_W'(id);
    return it;
  endfunction

  function automatic item_t link_item(int id, int ox, int oy, int oz,
                                      int lx, int ly, int lz, int hx, int hy, int hz);
    item_t it;
    it = plain_item(FUNC_LINK, id);
    it.origin_x = coord_t'(ox); it.origin_y = coord_t'(oy); it.origin_z = coord_t'(oz);
    it.box_lo_x = coord_t'(lx); it.box_lo_y = coord_t'(ly); it.box_lo_z = coord_t'(lz);
    it.box_hi_x = coord_t'(hx); it.box_hi_y = coord_t'(hy); it.box_hi_z = coord_t'(hz);
    return it;
  endfunction

  function automatic item_t query_item(int lx, int ly, int lz, int hx, int hy, int hz);
    item_t it;
    it = plain_item(FUNC_QUERY, $urandom_range(0, 1023));
    it.origin_x = coord_t'($urandom); it.origin_y = coord_t'($urandom);
    it.origin_z = coord_t'($urandom);
    it.box_lo_x = coord_t'(lx); it.box_lo_y = coord_t'(ly); it.box_lo_z = coord_t'(lz);
    it.box_hi_x = coord_t'(hx); it.box_hi_y = coord_t'(hy); it.box_hi_z = coord_t'(hz);
    return it;
  endfunction

  function automatic int world_point(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Well-formed random transaction with content drawn around the current world;
  // one in ten is raw noise over every bit of every field.
  function automatic item_t random_item(int span);
    item_t it;
    int    pick, c[3], s, id;
    pick = $urandom_range(99);
    id   = ($urandom_range(3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
    if (pick < 10) begin
      it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom});
      if (it.func == FUNC_CLEAR && $urandom_range(1) == 0) it.func = FUNC_QUERY;
    end else if (pick < 13) begin
      it = plain_item(FUNC_CLEAR, id);
    end else if (pick < 55) begin
      s = ($urandom_range(7) == 0) ? span / 2 : $urandom_range(0, 600);
      it = link_item(id, world_point(span), world_point(span), world_point(span),
                     -$urandom_range(0, s), -$urandom_range(0, s), -$urandom_range(0, s),
                     $urandom_range(0, s), $urandom_range(0, s), $urandom_range(0, s));
      if ($urandom_range(15) == 0) it.box_lo_x = it.box_hi_x + 100;
    end else if (pick < 72) begin
      it = plain_item(FUNC_UNLINK, id);
    end else begin
      for (int a = 0; a < 3; a++) c[a] = world_point(span);
      s = ($urandom_range(5) == 0) ? span : $urandom_range(0, span / 4);
      it = query_item(c[0] - s, c[1] - s, c[2] - s, c[0] + s, c[1] + s, c[2] + s);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, every operation, relink, saturation, inverted and touching boxes.
  task automatic test_directed();
    sender_idle_pct = 0;
    send_item(plain_item(FUNC_QUERY, 0));
    send_item(link_item(0, 0, 0, 0, -8, -8, -8, 8, 8, 8));
    send_item(link_item(1023, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                        8388607, 8388607, 8388607));
    send_item(link_item(5, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                        -8388608, -8388608, -8388608));
    send_item(link_item(6, 1000, 1000, 0, 50, 50, 50, -50, -50, -50));
    send_item(link_item(7, 300000, -300000, 0, 0, 0, 0, 16, 16, 16));
    send_item(link_item(0, 300000, 300000, 5, 0, 0, 0, 0, 0, 0));
    send_item(query_item(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_item(query_item(300008, 300008, 13, 300100, 300100, 100));
    send_item(query_item(300009, 300009, 14, 300100, 300100, 100));
    send_item(plain_item(FUNC_UNLINK, 7));
    send_item(plain_item(FUNC_UNLINK, 7));
    send_item(plain_item(FUNC_UNLINK, 512));
    send_item(query_item(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_item(query_item(10, 10, 10, -10, -10, -10));
    send_item(plain_item(FUNC_CLEAR, 0));
    send_item(plain_item(FUNC_UNLINK, 0));
    send_item(query_item(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
  endtask

  // Vary the bounds and the hit limit, extremes included; a clear applies each.
  task automatic test_config();
    int settings[4][5] = '{
      '{-8388608, 8388607, -8388608, 8388607, 1},
      '{-4096, 4096, -65536, 65536, 0},
      '{100, 100, -50, 900000, 127},
      '{-524288, 524288, -524288, 524288, 3}
    };
    for (int k = 0; k < 4; k++) begin
      program_index(settings[k][0], settings[k][1], settings[k][2], settings[k][3],
                    settings[k][4]);
      send_item(plain_item(FUNC_CLEAR, 0));
      for (int n = 0; n < 12; n++)
        send_item(link_item(n, world_point(8000), world_point(8000), 0,
                            -20, -20, -20, 20, 20, 20));
      send_item(query_item(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
      send_item(query_item(-2000, -2000, -50, 2000, 2000, 50));
    end
    program_index(-524288, 524288, -524288, 524288, 64);
    send_item(plain_item(FUNC_CLEAR, 0));
  endtask

  // Random traffic at one sender idle rate; pause for all results mid-way.
  task automatic test_random(int unsigned idle_pct, int unsigned count);
    sender_idle_pct = idle_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      send_item(random_item(524288));
    end
  endtask

  initial begin
    shadow_min_x = -524288; shadow_max_x = 524288;
    shadow_min_y = -524288; shadow_max_y = 524288;
    shadow_max_hits = 64;
    for (int e = 0; e < MAX_ENTITIES; e++) begin
      chain_link[e] = 0;
      home_node[e]  = 0;
      for (int a = 0; a < 3; a++) begin
        stored_lo[e][a] = 0;
        stored_hi[e][a] = 0;
      end
    end
    clear_index();
    sender_idle_pct = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config();
    test_random(0, 80);
    test_random(54, 80);
    test_random(22, 80);
    program_index(-1000000, 1000000, -200000, 200000, 5);
    send_item(plain_item(FUNC_CLEAR, 0));
    test_random(0, 20);

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Covered %0d transactions (clear, link, relink, unlink, query) over 6 register settings,",
             items_sent);
    $display("  %0d results checked, %0d query hits, %0d truncated queries, %0d mismatches",
             results_seen, hits_seen, trunc_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
